FILE: src/ffha_pkg.sv
// Package for the first-fit heap allocator unit.
// Holds item field widths, operation codes and the result struct; no dependencies.
package ffha_pkg;

  localparam int KIND_W = 2;
  localparam int REQ_W  = 13;
  localparam int FREE_W = 14;
  localparam int DOFF_W = 14;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_COMBINE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [DOFF_W-1:0] data_offset;
    logic              failed;
  } ffha_res_t;

endpackage

FILE: src/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator with output result register.
// Depends on ffha_pkg and ffha_seq.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | kind_i, req_size_i, free_offset_i
//   out     | output    | out_valid_o/out_stall_i | data_offset_o, failed_o
//
// From acceptance to result: allocate reads and checks the header of each block walked, then
// splits or takes the fitting block or appends at the break; combine reads and checks each block;
// free reads and rewrites one header. The shared header-store read port sets the walk.
// Reset clears the break offset and control; header entries are not reset, so a free must name a written header.
// A held result stalls new input items; the result waits in its register until taken.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 8192,
  parameter int HEADER_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [REQ_W-1:0]  req_size_i,
  input  logic [FREE_W-1:0] free_offset_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DOFF_W-1:0] data_offset_o,
  output logic              failed_o
);

  logic      idle, start, done;
  ffha_res_t res;
  logic      out_valid_q, out_valid_d;
  ffha_res_t out_q, out_d;

  assign in_stall_o = !idle || (out_valid_q && out_stall_i);
  assign start      = in_valid_i && !in_stall_o;

  ffha_seq #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .kind_i        (kind_i),
    .req_size_i    (req_size_i),
    .free_offset_i (free_offset_i),
    .idle_o        (idle),
    .done_o        (done),
    .res_o         (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (done) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign data_offset_o = out_q.data_offset;
  assign failed_o      = out_q.failed;

endmodule

FILE: src/ffha_hdr_mem.sv
// Header store: one entry per heap byte, one write and one registered read per cycle.
// No dependencies.
module ffha_hdr_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 15
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/ffha_step.sv
// Shared offset adder: a + b + header length, used for chain steps, splits and appends.
// No dependencies.
module ffha_step #(
  parameter int W      = 16,
  parameter int HEADER = 9
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] sum_o
);

  localparam logic [W-1:0] Hdr = W'(HEADER);

  assign sum_o = a_i + b_i + Hdr;

endmodule

FILE: src/ffha_seq.sv
// Sequencer and datapath: walks the block chain for allocate and combine, handles free.
// Depends on ffha_pkg, ffha_hdr_mem and ffha_step.
module ffha_seq
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 8192,
  parameter int HEADER_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [REQ_W-1:0]  req_size_i,
  input  logic [FREE_W-1:0] free_offset_i,
  output logic              idle_o,
  output logic              done_o,
  output ffha_res_t         res_o
);

  localparam int IW = $clog2(HEAP_BYTES);
  localparam int OW = $clog2(HEAP_BYTES + 1);
  localparam int SW = ((OW > FREE_W) ? OW : FREE_W) + 2;
  localparam int DW = OW + 1;
  localparam logic [SW-1:0] Hdr  = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] Heap = SW'(HEAP_BYTES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_ARD,
    S_ACHK,
    S_ASPL,
    S_APP,
    S_FRD,
    S_FWR,
    S_CRD,
    S_CCHK
  } state_e;

  state_e            state_q, state_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [SW-1:0]     req_q, req_d;
  logic [SW-1:0]     fo_q, fo_d;
  logic [SW-1:0]     cur_q, cur_d;
  logic [IW-1:0]     first_q, first_d;
  logic [SW-1:0]     sum_q, sum_d;
  logic              in_run_q, in_run_d;
  logic [OW-1:0]     brk_q, brk_d;
  logic              done_q, done_d;
  ffha_res_t         res_q, res_d;

  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [DW-1:0]     wr_data, rd_data;
  logic [SW-1:0]     step_a, step_b, step_s;

  logic              rd_free, fit;
  logic [SW-1:0]     rd_size, brk_w, cur_off, brk_off, free_at, rest_size;

  assign rd_free   = rd_data[OW];
  assign rd_size   = SW'(rd_data[OW-1:0]);
  assign fit       = rd_free && (rd_size >= req_q);
  assign brk_w     = SW'(brk_q);
  assign cur_off   = cur_q + Hdr;
  assign brk_off   = brk_w + Hdr;
  assign free_at   = fo_q - Hdr;
  assign rest_size = rd_size - req_q - Hdr;

  ffha_hdr_mem #(
    .DEPTH (HEAP_BYTES),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ffha_step #(
    .W      (SW),
    .HEADER (HEADER_BYTES)
  ) u_step (
    .a_i   (step_a),
    .b_i   (step_b),
    .sum_o (step_s)
  );

  always_comb begin
    step_a = cur_q;
    step_b = rd_size;
    case (state_q)
      S_ACHK: begin
        step_b = fit ? req_q : rd_size;
      end
      S_APP: begin
        step_a = brk_w;
        step_b = req_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    req_d    = req_q;
    fo_d     = fo_q;
    cur_d    = cur_q;
    first_d  = first_q;
    sum_d    = sum_q;
    in_run_d = in_run_q;
    brk_d    = brk_q;
    done_d   = 1'b0;
    res_d    = res_q;
    rd_en    = 1'b0;
    rd_addr  = cur_q[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = cur_q[IW-1:0];
    wr_data  = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d  = kind_i;
          req_d   = SW'(req_size_i);
          fo_d    = SW'(free_offset_i);
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        cur_d    = '0;
        in_run_d = 1'b0;
        res_d    = '0;
        case (kind_q)
          KIND_ALLOC: begin
            state_d = (brk_q != '0) ? S_ARD : S_APP;
          end
          KIND_FREE: begin
            if (fo_q < Hdr || free_at >= Heap) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_FRD;
            end
          end
          KIND_COMBINE: begin
            if (brk_q != '0) begin
              state_d = S_CRD;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_ARD: begin
        rd_en   = 1'b1;
        state_d = S_ACHK;
      end
      S_ACHK: begin
        if (fit) begin
          res_d.data_offset = cur_off[DOFF_W-1:0];
          if (rd_size > req_q + Hdr && step_s < Heap) begin
            wr_en   = 1'b1;
            wr_addr = step_s[IW-1:0];
            wr_data = {1'b1, rest_size[OW-1:0]};
            state_d = S_ASPL;
          end else begin
            wr_en   = 1'b1;
            wr_data = {1'b0, rd_size[OW-1:0]};
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cur_d   = step_s;
          state_d = (step_s < brk_w) ? S_ARD : S_APP;
        end
      end
      S_ASPL: begin
        wr_en   = 1'b1;
        wr_data = {1'b0, req_q[OW-1:0]};
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_APP: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (step_s > Heap) begin
          res_d.failed = 1'b1;
        end else begin
          wr_en             = 1'b1;
          wr_addr           = brk_w[IW-1:0];
          wr_data           = {1'b0, req_q[OW-1:0]};
          brk_d             = step_s[OW-1:0];
          res_d.data_offset = brk_off[DOFF_W-1:0];
        end
      end
      S_FRD: begin
        rd_en   = 1'b1;
        rd_addr = free_at[IW-1:0];
        state_d = S_FWR;
      end
      S_FWR: begin
        wr_en   = 1'b1;
        wr_addr = free_at[IW-1:0];
        wr_data = {1'b1, rd_data[OW-1:0]};
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_CRD: begin
        rd_en   = 1'b1;
        state_d = S_CCHK;
      end
      S_CCHK: begin
        if (!rd_free) begin
          if (in_run_q) begin
            wr_en   = 1'b1;
            wr_addr = first_q;
            wr_data = {1'b1, sum_q[OW-1:0]};
          end
          in_run_d = 1'b0;
        end else if (!in_run_q) begin
          in_run_d = 1'b1;
          first_d  = cur_q[IW-1:0];
          sum_d    = rd_size;
        end else begin
          sum_d = sum_q + Hdr + rd_size;
        end
        cur_d = step_s;
        if (step_s < brk_w) begin
          state_d = S_CRD;
        end else begin
          if (in_run_d) begin
            wr_en   = 1'b1;
            wr_addr = first_d;
            wr_data = {1'b1, sum_d[OW-1:0]};
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      brk_q    <= '0;
      in_run_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      brk_q    <= brk_d;
      in_run_q <= in_run_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    req_q   <= req_d;
    fo_q    <= fo_d;
    cur_q   <= cur_d;
    first_q <= first_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
  end

  assign idle_o = (state_q == S_IDLE) && !done_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  a_brk_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(brk_q) <= Heap)
    else $error("break offset beyond heap end");

  a_start_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> state_q == S_DISP)
    else $error("accepted item did not reach dispatch");

  a_walk_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACHK || state_q == S_CCHK) |-> cur_q < SW'(brk_q))
    else $error("chain walk beyond break offset");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result produced twice");

endmodule
